>>> sv/kmsd_pkg.sv
// Shared constants and types for the key matrix scan and debounce block.
`default_nettype none

package kmsd_pkg;

    // Matrix geometry defaults
    localparam int ROWS_DEFAULT = 6;
    localparam int COLS_DEFAULT = 20;

    // Rows carried by the row field of a column beat; rows above read as released
    localparam int SAMPLED_ROWS = 6;

    // Field widths of the beats
    localparam int COLUMN_W     = 5;
    localparam int ROW_BITS_W   = 6;
    localparam int ROW_INDEX_W  = 3;
    localparam int STABLE_ROW_W = 20;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;

    // Settle counter and its setting
    localparam int          DEBOUNCE_W     = 8;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd5;

    // Run queue status seen by the input handshake and the back end
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

`default_nettype wire

>>> sv/key_matrix_scan_debounce.sv
// Top level of the key matrix scanner with one shared debounce counter.
`default_nettype none

// Feed one beat per sampled column: the column number and its row levels, with
// tlast on the last column of a full scan. Any row bit that differs from the held
// raw sample is taken in and reloads the settle counter from debounce_scans; each
// scan end with a nonzero counter counts it down, and when it reaches zero the raw
// matrix becomes the stable matrix and ROWS result beats follow, row 0 first, tlast
// on the final row. Columns at or beyond COLS change nothing but still honour tlast.
// The input takes one column beat per clock; a settled matrix is snapshotted into a
// two-entry run queue and the output plays it out at one row beat per clock while
// m_tready is high, so the input holds tready low only while two runs wait behind
// the run on the output. debounce_scans resets to 5; the user writes it through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce this.
module key_matrix_scan_debounce #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT,
    parameter int COLS = kmsd_pkg::COLS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // debounce_scans write port
    input  wire logic                               cfg_we,
    input  wire logic [kmsd_pkg::DEBOUNCE_W-1:0]    cfg_wdata,
    // Column beats
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [kmsd_pkg::S_TDATA_W-1:0]     s_tdata,   // column[4:0], row_bits[10:5]
    input  wire logic                               s_tlast,   // scan_end
    // Stable row beats
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [kmsd_pkg::M_TDATA_W-1:0]          m_tdata,   // row_index[2:0], stable_row[22:3]
    output logic                                    m_tlast    // last_row
);

    kmsd_pkg::q_status_t  q_status;
    logic                 beat_fire;
    logic                 push, pop;
    logic [ROWS*COLS-1:0] push_data, head_data;

    // Hold off new columns only when the run queue has no room
    assign s_tready  = !q_status.full;
    assign beat_fire = s_tvalid && s_tready;

    kmsd_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .beat_fire (beat_fire),
        .column    (s_tdata[4:0]),
        .row_bits  (s_tdata[10:5]),
        .scan_end  (s_tlast),
        .push      (push),
        .push_data (push_data)
    );

    // Settled snapshots wait here so the input waits on the output only when the queue is full
    kmsd_queue #(
        .WIDTH (ROWS * COLS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .head_data (head_data)
    );

    kmsd_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_data (head_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

>>> sv/kmsd_front.sv
// Front end: takes column beats, tracks raw samples and the settle counter.
`default_nettype none

module kmsd_front #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT,
    parameter int COLS = kmsd_pkg::COLS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [kmsd_pkg::DEBOUNCE_W-1:0]     cfg_wdata,
    input  wire logic                                beat_fire,
    input  wire logic [kmsd_pkg::COLUMN_W-1:0]       column,
    input  wire logic [kmsd_pkg::ROW_BITS_W-1:0]     row_bits,
    input  wire logic                                scan_end,
    output logic                                     push,
    output logic [ROWS*COLS-1:0]                     push_data
);

    logic [kmsd_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic [kmsd_pkg::DEBOUNCE_W-1:0] count_reg, count_next, count_mid;
    logic [ROWS*COLS-1:0]            raw_reg, raw_next;
    logic [COLS-1:0]                 col_hot;
    logic [31:0]                     row_ext;
    logic                            changed;

    // One-hot column select; a column beyond the matrix selects nothing
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            col_hot[c] = (column == kmsd_pkg::COLUMN_W'(c));
        end
    end

    assign row_ext = 32'(row_bits);

    always_comb begin
        logic [COLS-1:0] now_vec;
        logic [COLS-1:0] old_row;
        raw_next = raw_reg;
        changed  = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            now_vec = (r < kmsd_pkg::SAMPLED_ROWS && row_ext[r]) ? '1 : '0;
            old_row = raw_reg[r*COLS +: COLS];
            if (|((old_row ^ now_vec) & col_hot)) begin
                changed = 1'b1;
            end
            raw_next[r*COLS +: COLS] = (old_row & ~col_hot) | (now_vec & col_hot);
        end
    end

    always_comb begin
        count_mid  = changed ? debounce_reg : count_reg;
        count_next = count_reg;
        push       = 1'b0;
        if (beat_fire) begin
            count_next = count_mid;
            if (scan_end && count_mid != '0) begin
                count_next = count_mid - 1'b1;
                push       = (count_mid == kmsd_pkg::DEBOUNCE_W'(1));
            end
        end
    end

    assign push_data = raw_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= kmsd_pkg::DEBOUNCE_RESET;
            count_reg    <= kmsd_pkg::DEBOUNCE_RESET;
            raw_reg      <= '0;
        end else begin
            if (cfg_we) begin
                debounce_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (beat_fire) begin
                raw_reg <= raw_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/kmsd_queue.sv
// Two-entry queue of settled matrix snapshots between front and back ends.
`default_nettype none

module kmsd_queue #(
    parameter int WIDTH = kmsd_pkg::ROWS_DEFAULT * kmsd_pkg::COLS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output kmsd_pkg::q_status_t     status,
    output logic [WIDTH-1:0]        head_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign status.full  = (count_reg == 2'd2);
    assign status.valid = (count_reg != 2'd0);
    assign head_data    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/kmsd_back.sv
// Back end: plays a settled snapshot out as a run of row beats.
`default_nettype none

module kmsd_back #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT,
    parameter int COLS = kmsd_pkg::COLS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire kmsd_pkg::q_status_t               q_status,
    input  wire logic [ROWS*COLS-1:0]              head_data,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [kmsd_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROWS*COLS-1:0] run_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 busy_reg;
    logic                 hs, last;
    logic [COLS-1:0]      sel_row;
    logic [31:0]          sel_ext, row_ext;
    logic [kmsd_pkg::STABLE_ROW_W-1:0] stable_row;

    assign hs   = busy_reg && m_tready;
    assign last = (row_reg == ROW_W'(ROWS - 1));
    assign pop  = q_status.valid && (!busy_reg || (hs && last));

    always_comb begin
        sel_row = '0;
        for (int r = 0; r < ROWS; r++) begin
            if (row_reg == ROW_W'(r)) begin
                sel_row = run_reg[r*COLS +: COLS];
            end
        end
    end

    assign sel_ext = 32'(sel_row);
    assign row_ext = 32'(row_reg);

    always_comb begin
        for (int c = 0; c < kmsd_pkg::STABLE_ROW_W; c++) begin
            stable_row[c] = (c < COLS) ? sel_ext[c] : 1'b0;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = {1'b0, stable_row, row_ext[kmsd_pkg::ROW_INDEX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (pop) begin
            run_reg <= head_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            row_reg  <= '0;
        end else if (hs) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/kmsd_checker.sv
// Port-level checks on the result run and their bind to the top level.
`default_nettype none

module kmsd_checker #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [kmsd_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);

    // A stalled row beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("row beat changed while stalled");

    // The run closes on the final row
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] == 3'(ROWS - 1)))
        else $error("tlast on a row other than the last");

    // Rows of a run follow one another without a gap
    a_next_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[2:0] == 3'($past(m_tdata[2:0]) + 3'd1)))
        else $error("row index did not advance within a run");

endmodule

bind key_matrix_scan_debounce kmsd_checker #(.ROWS(ROWS)) u_kmsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the key matrix scanner with shared debounce counter.
`timescale 1ns / 1ps

module testbench;

    localparam int ROWS        = kmsd_pkg::ROWS_DEFAULT;
    localparam int COLS        = kmsd_pkg::COLS_DEFAULT;
    localparam int COLUMN_W     = kmsd_pkg::COLUMN_W;
    localparam int ROW_BITS_W   = kmsd_pkg::ROW_BITS_W;
    localparam int ROW_INDEX_W  = kmsd_pkg::ROW_INDEX_W;
    localparam int STABLE_ROW_W = kmsd_pkg::STABLE_ROW_W;
    localparam int S_TDATA_W    = kmsd_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = kmsd_pkg::M_TDATA_W;
    localparam int DEBOUNCE_W   = kmsd_pkg::DEBOUNCE_W;
    // Cycles to let a column beat with no run finish inside the block before a register write
    localparam int CFG_PAUSE   = 16;
    // Cycles to keep watching after the last row beat is due
    localparam int TAIL_CYCLES = 20;
    // Cycles with no beat on either side before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // One stable row beat as it should leave the block
    typedef struct {
        logic [ROW_INDEX_W-1:0]  row_index;
        logic [STABLE_ROW_W-1:0] stable_row;
        logic                    last_row;
    } row_beat_t;

    // Directed steps: a checked beat, one with no run, one with a hand-written run, or a write
    typedef enum {
        STEP_PREDICTED,
        STEP_NO_RUN,
        STEP_UNIFORM_RUN,
        STEP_SET_DEBOUNCE
    } step_kind_t;

    typedef struct {
        step_kind_t              kind;
        logic [COLUMN_W-1:0]     column;
        logic [ROW_BITS_W-1:0]   row_bits;
        logic                    scan_end;
        logic [STABLE_ROW_W-1:0] run_row;    // every row of a hand-written run holds this
        logic [DEBOUNCE_W-1:0]   setting;
    } directed_step_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [DEBOUNCE_W-1:0]   cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;    // column[4:0], row_bits[10:5]
    logic                    s_tlast;    // scan_end
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;    // row_index[2:0], stable_row[22:3]
    logic                    m_tlast;    // last_row

    // Model of the block: raw and stable matrices, the settle counter and its setting
    logic [STABLE_ROW_W-1:0] raw_rows [ROWS];
    logic [STABLE_ROW_W-1:0] stable_rows [ROWS];
    logic [DEBOUNCE_W-1:0]   settle_count;
    logic [DEBOUNCE_W-1:0]   debounce_scans;

    row_beat_t               rows_due[$];
    directed_step_t          plan[$];
    int                      mismatches;
    int                      beats_sent;
    int                      stall_left;
    int                      idle_cycles;

    key_matrix_scan_debounce #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Gap length: mostly none, so that back-to-back stretches occur; sometimes short, rarely long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 2);
        end else if (roll < 97) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 30);
    endfunction

    // Row levels currently held in the raw matrix for one column; none beyond the matrix
    function automatic logic [ROW_BITS_W-1:0] held_column(input logic [COLUMN_W-1:0] column);
        logic [ROW_BITS_W-1:0] levels;
        levels = '0;
        if (column < COLS) begin
            for (int r = 0; r < ROWS; r++) begin
                levels[r] = raw_rows[r][column];
            end
        end
        return levels;
    endfunction

    function automatic directed_step_t make_step(input step_kind_t kind,
                                                 input logic [COLUMN_W-1:0] column,
                                                 input logic [ROW_BITS_W-1:0] row_bits,
                                                 input logic scan_end,
                                                 input logic [STABLE_ROW_W-1:0] run_row,
                                                 input logic [DEBOUNCE_W-1:0] setting);
        directed_step_t step;
        step.kind     = kind;
        step.column   = column;
        step.row_bits = row_bits;
        step.scan_end = scan_end;
        step.run_row  = run_row;
        step.setting  = setting;
        return step;
    endfunction

    // Queue a whole run of row beats, row 0 first, last_row on the final row
    task automatic queue_run(input logic [STABLE_ROW_W-1:0] run_rows [ROWS]);
        row_beat_t beat;
        for (int r = 0; r < ROWS; r++) begin
            beat.row_index  = r[ROW_INDEX_W-1:0];
            beat.stable_row = run_rows[r];
            beat.last_row   = (r == ROWS - 1);
            rows_due.push_back(beat);
        end
    endtask

    // Apply one accepted column beat to the model; queue the run it settles unless told not to
    task automatic take_column(input logic [COLUMN_W-1:0] column,
                               input logic [ROW_BITS_W-1:0] row_bits,
                               input logic scan_end,
                               input bit queue_result);
        // Columns outside the matrix touch nothing, but their scan end still counts
        if (column < COLS) begin
            for (int r = 0; r < ROWS; r++) begin
                if (row_bits[r] != raw_rows[r][column]) begin
                    raw_rows[r][column] = row_bits[r];
                    settle_count        = debounce_scans;
                end
            end
        end
        // Only the step from one to zero settles; an idle counter stays quiet
        if (scan_end && settle_count != '0) begin
            settle_count = settle_count - 1'b1;
            if (settle_count == '0) begin
                stable_rows = raw_rows;
                if (queue_result) begin
                    queue_run(stable_rows);
                end
            end
        end
    endtask

    // Present one column beat after a random gap, hold it until taken, then update the model
    task automatic send_column(input logic [COLUMN_W-1:0] column,
                               input logic [ROW_BITS_W-1:0] row_bits,
                               input logic scan_end,
                               input bit queue_result);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({row_bits, column});
        s_tlast  <= scan_end;
        do @(posedge aclk); while (s_tready !== 1'b1);
        beats_sent++;
        take_column(column, row_bits, scan_end, queue_result);
    endtask

    // Wait for every due row beat and for the block to settle, then write debounce_scans
    task automatic write_debounce(input logic [DEBOUNCE_W-1:0] setting);
        s_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(posedge aclk);
        repeat (CFG_PAUSE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        debounce_scans = setting;
    endtask

    // Noisy burst: random columns, levels often one flip away from the held sample, stray scan ends
    task automatic send_noise();
        int                    count;
        logic [COLUMN_W-1:0]   column;
        logic [ROW_BITS_W-1:0] row_bits;
        count = $urandom_range(2, 8);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 85) begin
                column = COLUMN_W'($urandom_range(0, COLS - 1));
            end else begin
                column = COLUMN_W'($urandom_range(COLS, 31));
            end
            if ($urandom_range(0, 1) == 1) begin
                row_bits = ROW_BITS_W'($urandom_range(0, 63));
            end else begin
                row_bits = held_column(column) ^ (6'd1 << $urandom_range(0, ROWS - 1));
            end
            send_column(column, row_bits, $urandom_range(0, 2) == 0, 1'b1);
        end
    endtask

    // Quiet scans: repeat the held sample (or junk on absent columns) until the counter runs out
    task automatic send_quiet_scans();
        int                    count;
        logic [COLUMN_W-1:0]   column;
        logic [ROW_BITS_W-1:0] row_bits;
        while (settle_count != '0) begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 99) < 90) begin
                    column   = COLUMN_W'($urandom_range(0, COLS - 1));
                    row_bits = held_column(column);
                end else begin
                    column   = COLUMN_W'($urandom_range(COLS, 31));
                    row_bits = ROW_BITS_W'($urandom_range(0, 63));
                end
                send_column(column, row_bits, i == count - 1, 1'b1);
            end
        end
    endtask

    task automatic report_mismatch(input row_beat_t want, input row_beat_t got, input bit stray);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            if (stray) begin
                $display("%0t: stray row beat: row %0d bits %05h last %0b",
                         $time, got.row_index, got.stable_row, got.last_row);
            end else begin
                $display("%0t: row beat mismatch: expected row %0d bits %05h last %0b,",
                         $time, want.row_index, want.stable_row, want.last_row);
                $display("    got row %0d bits %05h last %0b",
                         got.row_index, got.stable_row, got.last_row);
            end
        end
    endtask

    // Result side: check each taken row beat against the oldest one due, then pick the next stall.
    // The watchdog also lives here: it counts edges at which neither side moves a beat.
    always @(posedge aclk) begin
        row_beat_t got;
        row_beat_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.row_index  = m_tdata[ROW_INDEX_W-1:0];
            got.stable_row = m_tdata[ROW_INDEX_W +: STABLE_ROW_W];
            got.last_row   = m_tlast;
            if (rows_due.size() == 0) begin
                report_mismatch(got, got, 1'b1);
            end else begin
                want = rows_due.pop_front();
                if (got.row_index !== want.row_index || got.stable_row !== want.stable_row
                    || got.last_row !== want.last_row) begin
                    report_mismatch(want, got, 1'b0);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_tready <= 1'b1;
        end
        if ((s_tvalid === 1'b1 && s_tready === 1'b1)
            || (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [DEBOUNCE_W-1:0] settings [3];
        int phase_start;
        settings = '{8'd2, 8'd1, 8'd3};

        // Drive every input to a known level before the first edge
        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        m_tready   <= 1'b0;
        mismatches  = 0;
        beats_sent  = 0;
        stall_left  = 0;
        idle_cycles = 0;
        for (int r = 0; r < ROWS; r++) begin
            raw_rows[r]    = '0;
            stable_rows[r] = '0;
        end
        settle_count   = kmsd_pkg::DEBOUNCE_RESET;
        debounce_scans = kmsd_pkg::DEBOUNCE_RESET;

        // Directed steps. Under the reset setting of five, four quiet scan ends (one on an
        // absent column carrying pressed rows) bring the counter to one; the fifth settles
        // the untouched matrix, so an all-released run follows.
        plan.push_back(make_step(STEP_NO_RUN,      5'd0,  6'h00, 1'b1, '0, '0));
        plan.push_back(make_step(STEP_NO_RUN,      5'd0,  6'h00, 1'b0, '0, '0));
        plan.push_back(make_step(STEP_NO_RUN,      5'd31, 6'h3F, 1'b1, '0, '0));
        plan.push_back(make_step(STEP_NO_RUN,      5'd20, 6'h00, 1'b1, '0, '0));
        plan.push_back(make_step(STEP_NO_RUN,      5'd0,  6'h00, 1'b1, '0, '0));
        plan.push_back(make_step(STEP_UNIFORM_RUN, 5'd31, 6'h00, 1'b1, 20'h00000, '0));
        // Counter now idle at zero: a further scan end must not settle again
        plan.push_back(make_step(STEP_NO_RUN,      5'd0,  6'h00, 1'b1, '0, '0));
        // Fastest setting: a change and its scan end in one beat settle at once
        plan.push_back(make_step(STEP_SET_DEBOUNCE, 5'd0, 6'h00, 1'b0, '0, 8'd1));
        plan.push_back(make_step(STEP_UNIFORM_RUN, 5'd19, 6'h3F, 1'b1, 20'h80000, '0));
        plan.push_back(make_step(STEP_NO_RUN,      5'd0,  6'h3F, 1'b0, '0, '0));
        // Scan end on an absent column still counts down and settles the change above
        plan.push_back(make_step(STEP_UNIFORM_RUN, 5'd24, 6'h00, 1'b1, 20'h80001, '0));
        plan.push_back(make_step(STEP_PREDICTED,   5'd19, 6'h00, 1'b0, '0, '0));
        plan.push_back(make_step(STEP_PREDICTED,   5'd0,  6'h2A, 1'b1, '0, '0));
        plan.push_back(make_step(STEP_PREDICTED,   5'd7,  6'h15, 1'b0, '0, '0));
        plan.push_back(make_step(STEP_PREDICTED,   5'd7,  6'h15, 1'b1, '0, '0));
        // Slowest setting: a change loads 255, a second change reloads it
        plan.push_back(make_step(STEP_SET_DEBOUNCE, 5'd0, 6'h00, 1'b0, '0, 8'd255));
        plan.push_back(make_step(STEP_PREDICTED,   5'd12, 6'h3F, 1'b1, '0, '0));
        plan.push_back(make_step(STEP_PREDICTED,   5'd12, 6'h00, 1'b1, '0, '0));
        // Back to the fastest setting: a change reloads one and its scan end settles at once
        plan.push_back(make_step(STEP_SET_DEBOUNCE, 5'd0, 6'h00, 1'b0, '0, 8'd1));
        plan.push_back(make_step(STEP_PREDICTED,   5'd12, 6'h01, 1'b1, '0, '0));

        // Hold reset, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                STEP_SET_DEBOUNCE: begin
                    write_debounce(plan[i].setting);
                end
                STEP_PREDICTED: begin
                    send_column(plan[i].column, plan[i].row_bits, plan[i].scan_end, 1'b1);
                end
                STEP_NO_RUN: begin
                    send_column(plan[i].column, plan[i].row_bits, plan[i].scan_end, 1'b0);
                end
                STEP_UNIFORM_RUN: begin
                    logic [STABLE_ROW_W-1:0] run_rows [ROWS];
                    send_column(plan[i].column, plan[i].row_bits, plan[i].scan_end, 1'b0);
                    for (int r = 0; r < ROWS; r++) begin
                        run_rows[r] = plan[i].run_row;
                    end
                    queue_run(run_rows);
                end
                default: begin
                end
            endcase
        end

        // Random phases, one per setting: bursts of noise, then quiet scans until the matrix
        // settles, for at least 30 beats each.
        foreach (settings[p]) begin
            write_debounce(settings[p]);
            phase_start = beats_sent;
            do begin
                send_noise();
                send_quiet_scans();
            end while (beats_sent - phase_start < 30);
        end

        // Drop valid, wait out every due row beat, then watch a little longer for strays
        s_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
